>>> hdl/mru_pkg.sv
package mru_pkg;

  // payload and register widths
  localparam int VALUE_W      = 63;
  localparam int RESULT_W     = 32;
  localparam int ERROR_W      = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_IDX_W    = 1;
  localparam int SHIFT_W      = 6;
  localparam int MAX_SHIFT    = 32;
  localparam int MOD_BITS_DEF = 32;

  // step counter covers value bits plus the doubling steps
  localparam int CNT_W = $clog2(VALUE_W + MAX_SHIFT);

  // opcodes
  localparam logic OP_TO_MONT = 1'b0;
  localparam logic OP_REDC    = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT   = 1'b1;

  // error codes
  localparam logic [ERROR_W-1:0] ERR_OK     = 2'd0;
  localparam logic [ERROR_W-1:0] ERR_RANGE  = 2'd1;
  localparam logic [ERROR_W-1:0] ERR_CONFIG = 2'd2;

endpackage

>>> hdl/montgomery_reduction_unit_core.sv
// montgomery arithmetic unit, bit-serial
//
// command channel: start with op_i and value_i is taken at a clock edge where
// start is high and busy is low. one result per command: result_o and
// error_o are valid for exactly one cycle while done_o is high. the receiver
// cannot stall, so results are never held back.
// configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 modulus n, 1 shift k) at the clock edge; the user must do so only while no
// command runs, which the block itself does not enforce.
// steps from transfer to done_o:
//   convert (op 0): one remainder bit per cycle through the
//                   compare-subtract unit, then k doubling steps on it
//   reduce  (op 1): one radix-2 montgomery step per cycle, then an
//                   add of the high part and a final conditional subtract
//   bad configuration: answered from idle, with no steps run
// a new command may be given in the cycle done_o is high.
// reset clears the sequencer, drops done_o and sets n = 3, k = 2.
module montgomery_reduction_unit_core #(
  parameter int MOD_BITS = mru_pkg::MOD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            op_i,
  input  logic [mru_pkg::VALUE_W-1:0]     value_i,
  output logic                            done_o,
  output logic [mru_pkg::RESULT_W-1:0]    result_o,
  output logic [mru_pkg::ERROR_W-1:0]     error_o,
  input  logic                            cfg_we_i,
  input  logic [mru_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mru_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import mru_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_CORR = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [MOD_BITS-1:0] n_q, n_d;
  logic [SHIFT_W-1:0]  k_q, k_d;

  // datapath: operand shift register, accumulator, sum register
  logic [VALUE_W-1:0]  x_q, x_d;
  logic [MOD_BITS-1:0] acc_q, acc_d;
  logic [MOD_BITS:0]   t_q, t_d;
  logic                op_q, op_d;
  logic                rerr_q, rerr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  // output registers
  logic                done_q, done_d;
  logic [RESULT_W-1:0] result_q, result_d;
  logic [ERROR_W-1:0]  error_q, error_d;

  logic                cfg_ok;
  logic [CNT_W-1:0]    last_cnt;
  logic [MOD_BITS:0]   rem_w, rem_sub;
  logic                rem_ge;
  logic [MOD_BITS-1:0] div_next;
  logic                redc_odd;
  logic [MOD_BITS:0]   redc_sum;
  logic [MOD_BITS-1:0] redc_next;
  logic [MOD_BITS:0]   t_sum, t_sub;
  logic                t_ge;
  logic [MOD_BITS-1:0] corr_res;
  logic                range_err;

  // modulus must be odd and below 2^k, k nonzero and at most 32
  assign cfg_ok = n_q[0] && (k_q != '0) && ({1'b0, k_q} <= 7'(MAX_SHIFT))
                  && (({1'b0, k_q} >= 7'(MOD_BITS)) || ((n_q >> k_q) == '0));

  // convert runs 63 value bits then k zero bits, reduce runs k steps
  assign last_cnt = (op_q == OP_TO_MONT) ? CNT_W'(VALUE_W - 1) + CNT_W'(k_q)
                                         : CNT_W'(k_q) - CNT_W'(1);

  // restoring remainder step; zero fill after the value turns it into doubling
  assign rem_w    = {acc_q, x_q[VALUE_W-1]};
  assign rem_ge   = rem_w >= {1'b0, n_q};
  assign rem_sub  = rem_w - {1'b0, n_q};
  assign div_next = rem_ge ? rem_sub[MOD_BITS-1:0] : rem_w[MOD_BITS-1:0];

  // radix-2 montgomery step: bring in the next low bit, add n if odd, halve
  assign redc_odd  = acc_q[0] ^ x_q[0];
  assign redc_sum  = {1'b0, acc_q} + (redc_odd ? {1'b0, n_q} : '0)
                     + (MOD_BITS + 1)'(x_q[0]);
  assign redc_next = redc_sum[MOD_BITS:1];

  // after k steps x_q holds the high part of the operand
  assign t_sum     = {1'b0, acc_q} + {1'b0, x_q[MOD_BITS-1:0]};
  assign range_err = (|x_q[VALUE_W-1:MOD_BITS]) || (x_q[MOD_BITS-1:0] >= n_q);

  assign t_ge     = t_q >= {1'b0, n_q};
  assign t_sub    = t_q - {1'b0, n_q};
  assign corr_res = t_ge ? t_sub[MOD_BITS-1:0] : t_q[MOD_BITS-1:0];

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    k_d      = k_q;
    x_d      = x_q;
    acc_d    = acc_q;
    t_d      = t_q;
    op_d     = op_q;
    rerr_d   = rerr_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    result_d = result_q;
    error_d  = error_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODULUS: n_d = cfg_data_i[MOD_BITS-1:0];
        REG_SHIFT:   k_d = cfg_data_i[SHIFT_W-1:0];
        default:     ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          x_d   = value_i;
          op_d  = op_i;
          acc_d = '0;
          cnt_d = '0;
          if (cfg_ok) begin
            state_d = ST_RUN;
          end else begin
            // bad configuration answers at once
            done_d   = 1'b1;
            result_d = '0;
            error_d  = ERR_CONFIG;
          end
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (op_q == OP_TO_MONT) begin
          acc_d = div_next;
          x_d   = {x_q[VALUE_W-2:0], 1'b0};
        end else begin
          acc_d = redc_next;
          x_d   = {1'b0, x_q[VALUE_W-1:1]};
        end
        if (cnt_q == last_cnt) begin
          if (op_q == OP_TO_MONT) begin
            state_d  = ST_IDLE;
            done_d   = 1'b1;
            result_d = RESULT_W'(div_next);
            error_d  = ERR_OK;
          end else begin
            state_d = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        t_d     = t_sum;
        rerr_d  = range_err;
        state_d = ST_CORR;
      end
      ST_CORR: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        if (rerr_q) begin
          result_d = '0;
          error_d  = ERR_RANGE;
        end else begin
          result_d = RESULT_W'(corr_res);
          error_d  = ERR_OK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= MOD_BITS'(3);
      k_q     <= SHIFT_W'(2);
      done_q  <= 1'b0;
      cnt_q   <= '0;
      op_q    <= OP_TO_MONT;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      k_q     <= k_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      op_q    <= op_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    acc_q    <= acc_d;
    t_q      <= t_d;
    rerr_q   <= rerr_d;
    result_q <= result_d;
    error_q  <= error_d;
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;
  assign error_o  = error_q;

endmodule

>>> hdl/mru_checker.sv
module mru_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            op_i,
  input logic [mru_pkg::VALUE_W-1:0]     value_i,
  input logic                            done_o,
  input logic [mru_pkg::RESULT_W-1:0]    result_o,
  input logic [mru_pkg::ERROR_W-1:0]     error_o,
  input logic                            cfg_we_i,
  input logic [mru_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input logic [mru_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import mru_pkg::*;

  // an accepted command either starts running or answers in the next cycle
  a_accept_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted command neither ran nor answered");

  // busy only rises after a transfer
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");

  // a result follows work in flight or a command just taken
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) || $past(start)))
    else $error("result without a command");

  // error answers carry a zero result and a known code
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (error_o != ERR_OK)) |->
      ((result_o == '0) && ((error_o == ERR_RANGE) || (error_o == ERR_CONFIG))))
    else $error("bad error answer");

  // a range error only comes from a reduction
  a_range_redc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_i == OP_TO_MONT)) |=> !(done_o && (error_o == ERR_RANGE)))
    else $error("range error on conversion");

endmodule

bind montgomery_reduction_unit_core mru_checker u_mru_checker (.*);

>>> dv/montgomery_reduction_unit_core_tb.sv
`timescale 1ns / 1ps

module montgomery_reduction_unit_core_tb;
  import mru_pkg::*;

  // longest run of cycles with neither a command transfer nor a result
  localparam int unsigned STALL_LIMIT   = 5000;
  // quiet cycles after the last result: covers a full convert at k = 32
  localparam int unsigned TAIL_CYCLES   = 128;
  localparam int unsigned BLOCKS        = 24;
  localparam int unsigned BLOCK_ITEMS   = 84;
  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  typedef struct packed {
    logic [RESULT_W-1:0] result;
    logic [ERROR_W-1:0]  error;
  } mont_result_t;

  // keeps its own copy of the registers and the cached inverse, works out the
  // answer of every accepted command and checks results against it in order
  class mont_scoreboard;
    bit [CFG_DATA_W-1:0] modulus;
    bit [SHIFT_W-1:0]    shift;
    bit [RESULT_W-1:0]   n_inverse;
    bit                  inverse_ok;
    mont_result_t        awaited[$];
    int unsigned         failures;

    function new();
      modulus    = 3;
      shift      = 2;
      n_inverse  = '0;
      inverse_ok = 1'b0;
      failures   = 0;
    endfunction

    function void note_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_MODULUS) begin
        modulus = data;
      end else begin
        shift = data[SHIFT_W-1:0];
      end
      inverse_ok = 1'b0;
    endfunction

    // n^-1 mod 2^32, six newton steps from one
    function bit [RESULT_W-1:0] newton_inverse(bit [RESULT_W-1:0] n);
      bit [RESULT_W-1:0] v;
      v = 1;
      repeat (6) v = v * (32'd2 - n * v);
      return v;
    endfunction

    function void note_command(logic op, logic [VALUE_W-1:0] x);
      bit [63:0]    n, msk, q, qn, res;
      int unsigned  k;
      mont_result_t want;
      n   = {32'd0, modulus};
      k   = shift;
      res = '0;
      want.error = ERR_OK;
      if (k > MAX_SHIFT || !modulus[0] || n >= (64'd1 << k)) begin
        want.error = ERR_CONFIG;
      end else if (op == OP_TO_MONT) begin
        // reduce first, then k doublings each folded back below n
        res = {1'b0, x} % n;
        repeat (k) begin
          res = res << 1;
          if (res >= n) res = res - n;
        end
      end else if ({1'b0, x} >= (n << k)) begin
        want.error = ERR_RANGE;
      end else begin
        if (!inverse_ok) begin
          n_inverse  = newton_inverse(modulus);
          inverse_ok = 1'b1;
        end
        msk = (64'd1 << k) - 1;
        q   = (({1'b0, x} & msk) * {32'd0, n_inverse}) & msk;
        qn  = q * n;
        // x - q*n is a multiple of R; wrap a negative quotient by adding n
        if ({1'b0, x} >= qn) res = ({1'b0, x} - qn) >> k;
        else res = n - ((qn - {1'b0, x}) >> k);
      end
      want.result = res[RESULT_W-1:0];
      awaited.push_back(want);
    endfunction

    function void check_result(logic [RESULT_W-1:0] result, logic [ERROR_W-1:0] error);
      mont_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing awaited: result %h error %0d",
                 $time, result, error);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (result !== want.result) begin
        $display("%0t: result mismatch: expected %h actual %h", $time, want.result, result);
        failures++;
      end
      if (error !== want.error) begin
        $display("%0t: error mismatch: expected %0d actual %0d", $time, want.error, error);
        failures++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic                  op_i;
  logic [VALUE_W-1:0]    value_i;
  logic                  done_o;
  logic [RESULT_W-1:0]   result_o;
  logic [ERROR_W-1:0]    error_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mont_scoreboard        sb = new();
  int unsigned           sender_idle_pct;
  int unsigned           quiet_cycles;
  bit [CFG_DATA_W-1:0]   cfg_modulus;
  bit [SHIFT_W-1:0]      cfg_shift;

  montgomery_reduction_unit_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .op_i       (op_i),
    .value_i    (value_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .error_o    (error_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // results are sampled before this edge's updates land, so the values seen
  // are the ones held during the cycle that the edge closes
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(result_o, error_o);
    // watchdog: anything transferred in either direction restarts the count
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("montgomery_reduction_unit_core_tb failed");
        $finish;
      end
    end
  end

  function automatic logic [VALUE_W-1:0] rand_value();
    return VALUE_W'({$urandom(), $urandom()} >> 1);
  endfunction

  // operand for the current setting: reductions are mostly legal operands,
  // with the range edges and some out-of-range noise mixed in
  function automatic logic [VALUE_W-1:0] pick_operand(logic op);
    bit [63:0]          lim;
    logic [VALUE_W-1:0] r;
    int unsigned        sel;
    r   = rand_value();
    sel = $urandom_range(19);
    if (op == OP_TO_MONT) begin
      if (sel < 5) return VALUE_W'(r % ({32'd0, cfg_modulus} * 2 + 1));
      return r;
    end
    if (cfg_shift > MAX_SHIFT) return r;
    lim = {32'd0, cfg_modulus} << cfg_shift;
    if (lim == 0 || lim > {1'b0, VALUE_MAX}) return r;
    case (sel)
      0: return '0;
      1: return VALUE_W'(lim - 1);
      2: return VALUE_W'(lim);
      3, 4: return r;
      default: return VALUE_W'(r % lim);
    endcase
  endfunction

  // start is redrawn every cycle, so gaps land on every phase of a command
  task automatic issue_command(input logic op, input logic [VALUE_W-1:0] operand);
    op_i    <= op;
    value_i <= operand;
    forever begin
      start <= ($urandom_range(99) >= sender_idle_pct);
      @(posedge clk_i);
      if (start && !busy) break;
    end
    sb.note_command(op, operand);
  endtask

  // every command answers once, so an empty queue and a low busy mean idle
  task automatic drain();
    start <= 1'b0;
    while (sb.awaited.size() != 0 || busy) @(posedge clk_i);
  endtask

  // writes both registers; unused high bits of the shift word are random
  task automatic set_config(input bit [CFG_DATA_W-1:0] n, input bit [SHIFT_W-1:0] k);
    bit [CFG_DATA_W-1:0] kword;
    kword = ($urandom() & ~32'h3F) | k;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_MODULUS;
    cfg_data_i <= n;
    @(posedge clk_i);
    sb.note_reg_write(REG_MODULUS, n);
    cfg_idx_i  <= REG_SHIFT;
    cfg_data_i <= kword;
    @(posedge clk_i);
    sb.note_reg_write(REG_SHIFT, kword);
    cfg_we_i    <= 1'b0;
    cfg_modulus = n;
    cfg_shift   = k;
  endtask

  // one random setting per block: mostly odd moduli below R, plus the
  // extremes and the ways a setting can be illegal
  task automatic random_config();
    bit [63:0]   msk;
    int unsigned k;
    case ($urandom_range(11))
      0: set_config(32'hFFFF_FFFF, 6'd32);
      1: begin
        k = $urandom_range(1, 3);
        set_config(($urandom() & ((32'd1 << k) - 1)) | 32'd1, SHIFT_W'(k));
      end
      2: begin
        case ($urandom_range(3))
          0: set_config($urandom() & ~32'd1, SHIFT_W'($urandom_range(2, 32)));
          1: begin
            k = $urandom_range(1, 31);
            set_config($urandom() | (32'd1 << k) | 32'd1, SHIFT_W'(k));
          end
          2: set_config($urandom() | 32'd1, SHIFT_W'($urandom_range(33, 63)));
          default: set_config($urandom(), 6'd0);
        endcase
      end
      default: begin
        k   = $urandom_range(2, 32);
        msk = (64'd1 << k) - 1;
        set_config(($urandom() & msk[31:0]) | 32'd1, SHIFT_W'(k));
      end
    endcase
  endtask

  initial begin
    rst_ni          <= 1'b0;
    start           <= 1'b0;
    op_i            <= OP_TO_MONT;
    value_i         <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= REG_MODULUS;
    cfg_data_i      <= '0;
    sender_idle_pct = 0;
    cfg_modulus     = 3;
    cfg_shift       = 2;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting n = 3, k = 2: inverse not yet computed, range edge at 12
    issue_command(OP_TO_MONT, '0);
    issue_command(OP_TO_MONT, VALUE_MAX);
    issue_command(OP_REDC, '0);
    issue_command(OP_REDC, 63'd11);
    issue_command(OP_REDC, 63'd12);
    issue_command(OP_REDC, VALUE_MAX);

    // widest modulus and radix: n*R exceeds the operand range
    drain();
    set_config(32'hFFFF_FFFF, 6'd32);
    issue_command(OP_TO_MONT, VALUE_MAX);
    issue_command(OP_TO_MONT, 63'h5555_5555_5555_5555);
    issue_command(OP_REDC, VALUE_MAX);
    issue_command(OP_REDC, 63'h2AAA_AAAA_AAAA_AAAA);
    issue_command(OP_REDC, '0);

    // modulus of one, every answer is zero
    drain();
    set_config(32'd1, 6'd1);
    issue_command(OP_TO_MONT, 63'h1234_5678_9ABC_DEF0);
    issue_command(OP_REDC, 63'd1);
    issue_command(OP_REDC, 63'd2);

    // illegal settings: even modulus, modulus not below R, k too big, k zero
    drain();
    set_config(32'd4, 6'd8);
    issue_command(OP_TO_MONT, 63'd100);
    issue_command(OP_REDC, 63'd5);
    drain();
    set_config(32'd257, 6'd8);
    issue_command(OP_TO_MONT, 63'd300);
    issue_command(OP_REDC, 63'd1);
    drain();
    set_config(32'd5, 6'd33);
    issue_command(OP_REDC, 63'd3);
    drain();
    set_config(32'd1, 6'd0);
    issue_command(OP_TO_MONT, 63'd7);
    drain();
    set_config(32'd7, 6'd63);
    issue_command(OP_REDC, 63'd1);

    // random blocks: sender idles often at first, then mostly, then never
    for (int unsigned b = 0; b < BLOCKS; b++) begin
      drain();
      random_config();
      sender_idle_pct = (b < BLOCKS / 3) ? 23 : (b < 2 * BLOCKS / 3) ? 87 : 0;
      for (int unsigned i = 0; i < BLOCK_ITEMS; i++) begin
        logic op;
        op = 1'($urandom_range(1));
        issue_command(op, pick_operand(op));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.awaited.size() == 0) begin
      $display("montgomery_reduction_unit_core_tb passed");
    end else begin
      $display("montgomery_reduction_unit_core_tb failed");
    end
    $finish;
  end

endmodule
